FILE: design/dual_motor_pid_distance_control_macros.svh
// ----------------------------------------------------------------------------
// Dual motor PID controller - assertion macros
// Concurrent assertion wrappers on clk_i / rst_ni of the including module.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_PID_DISTANCE_CONTROL_MACROS_SVH
`define DUAL_MOTOR_PID_DISTANCE_CONTROL_MACROS_SVH

// Checked outside reset only
`define DMPDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define DMPDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: design/dmpdc_pkg.sv
// ----------------------------------------------------------------------------
// Dual motor PID controller - package
// Shared constants, register codes and control structs.
// ----------------------------------------------------------------------------
package dmpdc_pkg;

  // Parameter defaults
  localparam int PWM_MAX_DEF    = 100;
  localparam int COUNT_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // Field widths
  localparam int CNT_W  = 16;
  localparam int GAIN_W = 16;
  localparam int DIST_W = 31;
  localparam int FLAG_W = 3;
  localparam int DUTY_W = 7;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 31;

  localparam logic signed [GAIN_W-1:0] KP_RESET = 16'sd205;

  // Control flag bits
  localparam int FLAG_DIST = 0;
  localparam int FLAG_LDIR = 1;
  localparam int FLAG_RDIR = 2;

  // Register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_LTGT   = 3'd3,
    REG_RTGT   = 3'd4,
    REG_LDIST  = 3'd5,
    REG_RDIST  = 3'd6,
    REG_FLAGS  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    gains_t              gains;
    logic [CNT_W-1:0]    left_target;
    logic [CNT_W-1:0]    right_target;
    logic [DIST_W-1:0]   left_dist;
    logic [DIST_W-1:0]   right_dist;
    logic [FLAG_W-1:0]   flags;
  } cfg_t;

  // Travel/done clear strobes from distance writes
  typedef struct packed {
    logic left;
    logic right;
  } clr_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              left_dir;
    logic              right_dir;
    logic              left_done;
    logic              right_done;
  } res_t;

endpackage

FILE: design/dmpdc_in_if.sv
// ----------------------------------------------------------------------------
// Dual motor PID controller - input channel
// Valid/ready channel carrying one encoder sample pair per item.
// ----------------------------------------------------------------------------
interface dmpdc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_count;
  logic [15:0] right_count;

  modport source (output valid, output left_count, output right_count, input ready);
  modport sink   (input valid, input left_count, input right_count, output ready);
endinterface

FILE: design/dmpdc_out_if.sv
// ----------------------------------------------------------------------------
// Dual motor PID controller - result channel
// Valid/ready channel carrying duty, direction and done per item.
// ----------------------------------------------------------------------------
interface dmpdc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] left_duty_out;
  logic [6:0] right_duty_out;
  logic       left_dir_out;
  logic       right_dir_out;
  logic       left_done_out;
  logic       right_done_out;

  modport source (output valid, output left_duty_out, output right_duty_out,
                  output left_dir_out, output right_dir_out,
                  output left_done_out, output right_done_out, input ready);
  modport sink   (input valid, input left_duty_out, input right_duty_out,
                  input left_dir_out, input right_dir_out,
                  input left_done_out, input right_done_out, output ready);
endinterface

FILE: design/dmpdc_cfg.sv
// ----------------------------------------------------------------------------
// Dual motor PID controller - configuration registers
// Write-only register file; distance writes pulse a channel clear.
// ----------------------------------------------------------------------------
module dmpdc_cfg
  import dmpdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [CFG_AW-1:0] idx_i,
  input  logic [CFG_DW-1:0] data_i,
  output cfg_t              cfg_o,
  output clr_t              clr_o
);

  // Reset image: default proportional gain, everything else zero
  localparam cfg_t CfgReset = '{
    gains:        '{kp: KP_RESET, ki: '0, kd: '0},
    left_target:  '0,
    right_target: '0,
    left_dist:    '0,
    right_dist:   '0,
    flags:        '0
  };

  cfg_t     cfg_q, cfg_d;
  cfg_idx_e idx;

  assign idx = cfg_idx_e'(idx_i);

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    clr_o = '0;
    if (we_i) begin
      unique case (idx)
        REG_KP:    cfg_d.gains.kp    = data_i[GAIN_W-1:0];
        REG_KI:    cfg_d.gains.ki    = data_i[GAIN_W-1:0];
        REG_KD:    cfg_d.gains.kd    = data_i[GAIN_W-1:0];
        REG_LTGT:  cfg_d.left_target  = data_i[CNT_W-1:0];
        REG_RTGT:  cfg_d.right_target = data_i[CNT_W-1:0];
        REG_LDIST: begin
          cfg_d.left_dist = data_i[DIST_W-1:0];
          clr_o.left      = 1'b1;
        end
        REG_RDIST: begin
          cfg_d.right_dist = data_i[DIST_W-1:0];
          clr_o.right      = 1'b1;
        end
        REG_FLAGS: cfg_d.flags = data_i[FLAG_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/dmpdc_chan.sv
// ----------------------------------------------------------------------------
// Dual motor PID controller - one motor channel
// Travel limit, incremental PID step and duty clamp, with channel state.
// ----------------------------------------------------------------------------
module dmpdc_chan
  import dmpdc_pkg::*;
#(
  parameter int PWM_MAX    = PWM_MAX_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              clr_i,
  input  logic              dist_mode_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic [CNT_W-1:0]  target_i,
  input  logic [DIST_W-1:0] distance_i,
  input  gains_t            gains_i,
  output logic [DUTY_W-1:0] duty_o,
  output logic              done_o
);

  localparam int DW = (PWM_MAX > 1) ? $clog2(PWM_MAX + 1) : 1;
  localparam logic [CNT_W-1:0] CntMask =
    (COUNT_BITS >= CNT_W) ? {CNT_W{1'b1}} : CNT_W'((64'd1 << COUNT_BITS) - 64'd1);
  localparam logic signed [49:0] RoundAdj = 50'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [50:0] PwmMaxS  = 51'(PWM_MAX);
  localparam logic [DW-1:0]      PwmMax   = DW'(PWM_MAX);

  // Channel state
  logic [DW-1:0]      duty_q, duty_d;
  logic signed [31:0] integ_q, integ_d;
  logic signed [16:0] perr_q;
  logic [31:0]        travel_q, travel_d;
  logic               done_q;

  logic [CNT_W-1:0]   count;
  logic [32:0]        travel_sum;
  logic               limited;
  logic signed [16:0] err;
  logic signed [32:0] isum;
  logic signed [17:0] derr;
  logic signed [32:0] p_prod;
  logic signed [47:0] i_prod;
  logic signed [33:0] d_prod;
  logic signed [49:0] acc;
  logic signed [49:0] step;
  logic signed [50:0] nd;
  logic [DW-1:0]      duty_sel;
  logic [DW+6:0]      duty_ext;

  assign count = count_i & CntMask;

  // Saturating travel total and limit check
  assign travel_sum = {1'b0, travel_q} + {17'b0, count};
  assign travel_d   = dist_mode_i ? (travel_sum[32] ? 32'hFFFF_FFFF : travel_sum[31:0])
                                  : travel_q;
  assign limited    = travel_d > {1'b0, distance_i};

  // Error and saturating integral
  assign err  = $signed({1'b0, target_i}) - $signed({1'b0, count});
  assign isum = {integ_q[31], integ_q} + {{16{err[16]}}, err};
  always_comb begin
    if (isum[32] != isum[31]) begin
      integ_d = isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      integ_d = isum[31:0];
    end
  end
  assign derr = {err[16], err} - {perr_q[16], perr_q};

  // PID terms, all exact
  assign p_prod = gains_i.kp * err;
  assign i_prod = gains_i.ki * integ_d;
  assign d_prod = gains_i.kd * derr;
  assign acc    = 50'(p_prod) + 50'(i_prod) + 50'(d_prod);

  // Scale down, truncating toward zero
  assign step = (acc + (acc[49] ? RoundAdj : 50'sd0)) >>> FRAC_BITS;

  // New duty, clamped to 0..PWM_MAX
  assign nd = 51'(step) + $signed({{(51-DW){1'b0}}, duty_q});
  always_comb begin
    priority if (nd < 51'sd0) begin
      duty_d = '0;
    end else if (nd > PwmMaxS) begin
      duty_d = PwmMax;
    end else begin
      duty_d = nd[DW-1:0];
    end
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q   <= '0;
      integ_q  <= '0;
      perr_q   <= '0;
      travel_q <= '0;
      done_q   <= 1'b0;
    end else if (clr_i) begin
      travel_q <= '0;
      done_q   <= 1'b0;
    end else if (fire_i) begin
      travel_q <= travel_d;
      if (limited) begin
        done_q <= 1'b1;
      end else begin
        duty_q  <= duty_d;
        integ_q <= integ_d;
        perr_q  <= err;
      end
    end
  end

  // Result fields for this item
  assign duty_sel = limited ? '0 : duty_d;
  assign duty_ext = {7'b0, duty_sel};
  assign duty_o   = duty_ext[DUTY_W-1:0];
  assign done_o   = limited | done_q;

endmodule

FILE: design/dual_motor_pid_distance_control.sv
// From input accept to result valid: input register, then result register.
// Throughput: 1 item per cycle while the result side is ready; the limit is the combinational
// channel step (integral add, three parallel multiplies, sum, scale and duty clamp).
// Reset (rst_ni low, asynchronous): gains, targets, limits, flags, channel state
// and both pipeline valids return to their reset values; no clearing pass.
// ----------------------------------------------------------------------------
// Dual motor PID controller - top level
// Two-channel incremental PID duty control with optional travel limit.
// ----------------------------------------------------------------------------
`include "dual_motor_pid_distance_control_macros.svh"

module dual_motor_pid_distance_control
  import dmpdc_pkg::*;
#(
  parameter int PWM_MAX    = PWM_MAX_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  dmpdc_in_if.sink          in_i,
  dmpdc_out_if.source       out_o
);

  cfg_t              cfg;
  clr_t              clr;
  logic              in_valid_q, in_valid_d;
  logic [CNT_W-1:0]  lcnt_q, rcnt_q;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;
  logic              advance, fire, in_take;
  logic [DUTY_W-1:0] l_duty, r_duty;
  logic              l_done, r_done;

  dmpdc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg),
    .clr_o  (clr)
  );

  // Handshake: result register drains, input register refills each cycle unless the result side stalls
  assign advance     = !out_valid_q || out_o.ready;
  assign fire        = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || fire;
  assign in_take     = in_i.valid && in_i.ready;
  assign in_valid_d  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input sample register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      lcnt_q <= in_i.left_count;
      rcnt_q <= in_i.right_count;
    end
  end

  // Channel datapaths
  dmpdc_chan #(
    .PWM_MAX    (PWM_MAX),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .clr_i       (clr.left),
    .dist_mode_i (cfg.flags[FLAG_DIST]),
    .count_i     (lcnt_q),
    .target_i    (cfg.left_target),
    .distance_i  (cfg.left_dist),
    .gains_i     (cfg.gains),
    .duty_o      (l_duty),
    .done_o      (l_done)
  );

  dmpdc_chan #(
    .PWM_MAX    (PWM_MAX),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .clr_i       (clr.right),
    .dist_mode_i (cfg.flags[FLAG_DIST]),
    .count_i     (rcnt_q),
    .target_i    (cfg.right_target),
    .distance_i  (cfg.right_dist),
    .gains_i     (cfg.gains),
    .duty_o      (r_duty),
    .done_o      (r_done)
  );

  // Result fields for this item
  assign res_d = '{
    left_duty:  l_duty,
    right_duty: r_duty,
    left_dir:   cfg.flags[FLAG_LDIR],
    right_dir:  cfg.flags[FLAG_RDIR],
    left_done:  l_done,
    right_done: r_done
  };

  // Result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.left_duty_out  = res_q.left_duty;
  assign out_o.right_duty_out = res_q.right_duty;
  assign out_o.left_dir_out   = res_q.left_dir;
  assign out_o.right_dir_out  = res_q.right_dir;
  assign out_o.left_done_out  = res_q.left_done;
  assign out_o.right_done_out = res_q.right_done;

  // Assertions
  `DMPDC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!in_valid_q && !out_valid_q), "pipeline not empty in reset")
  `DMPDC_ASSERT(a_in_hold, (in_valid_q && !advance) |=> (in_valid_q && $stable(lcnt_q) && $stable(rcnt_q)), "stalled sample lost")
  `DMPDC_ASSERT(a_left_done_zero, (out_valid_q && res_q.left_done) |-> (res_q.left_duty == '0), "left done with nonzero duty")
  `DMPDC_ASSERT(a_right_done_zero, (out_valid_q && res_q.right_done) |-> (res_q.right_duty == '0), "right done with nonzero duty")

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Dual motor PID controller - regression testbench
// Sends encoder sample pairs, with random gaps and result stalls, into the
// controller. A local model of the two PID wheels predicts duty, direction
// and done for every accepted item, and each result is checked against the
// oldest prediction. Directed tests come first: reset values, gain and count
// extremes, travel limits, runs at full count. A randomized mix of settings
// and samples follows.
// ----------------------------------------------------------------------------
module tb;
  import dmpdc_pkg::*;

  localparam int PWM_MAX     = PWM_MAX_DEF;
  localparam int FRAC_BITS   = FRAC_BITS_DEF;
  localparam int QUIET_LIMIT = 1000;

  // Per-wheel model state and settings
  typedef struct {
    logic [DUTY_W-1:0]     duty;
    logic signed [31:0]    integral;
    logic signed [CNT_W:0] prev_err;
    logic [31:0]           travel;
    logic                  done;
    logic [CNT_W-1:0]      target;
    logic [DIST_W-1:0]     limit;
  } wheel_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  cfg_idx_e          cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  dmpdc_in_if  in_ch ();
  dmpdc_out_if out_ch ();

  dual_motor_pid_distance_control dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  logic signed [GAIN_W-1:0] gain_kp;
  logic signed [GAIN_W-1:0] gain_ki;
  logic signed [GAIN_W-1:0] gain_kd;
  logic [FLAG_W-1:0]        ctrl_flags;
  wheel_t                   wheel [2];
  res_t                     motor_cmd_q [$];
  int                       err_count = 0;
  bit                       idle_on = 1'b1;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reset_model();
    gain_kp    = KP_RESET;
    gain_ki    = '0;
    gain_kd    = '0;
    ctrl_flags = '0;
    for (int s = 0; s < 2; s++) begin
      wheel[s].duty     = '0;
      wheel[s].integral = '0;
      wheel[s].prev_err = '0;
      wheel[s].travel   = '0;
      wheel[s].done     = 1'b0;
      wheel[s].target   = '0;
      wheel[s].limit    = '0;
    end
  endfunction

  // One wheel: travel update, limit check, then incremental PID on the duty
  function automatic logic [DUTY_W-1:0] pid_wheel_step(int side, logic [CNT_W-1:0] cnt,
                                                       logic dist_on);
    longint tsum, err, isum, delta, acc, mag, nd;
    if (dist_on) begin
      tsum = longint'(wheel[side].travel) + longint'(cnt);
      if (tsum > 64'sd4294967295) wheel[side].travel = 32'hFFFF_FFFF;
      else wheel[side].travel = tsum[31:0];
    end
    // limited wheel holds its PID state and is marked done, only the output duty drops to zero
    if (wheel[side].travel > {1'b0, wheel[side].limit}) begin
      wheel[side].done = 1'b1;
      return '0;
    end
    err  = longint'(wheel[side].target) - longint'(cnt);
    isum = longint'(wheel[side].integral) + err;
    if (isum > 64'sd2147483647) isum = 64'sd2147483647;
    if (isum < -64'sd2147483648) isum = -64'sd2147483648;
    wheel[side].integral = isum[31:0];
    delta = err - longint'(wheel[side].prev_err);
    acc   = longint'(gain_kp) * err + longint'(gain_ki) * isum + longint'(gain_kd) * delta;
    wheel[side].prev_err = err[CNT_W:0];
    // scale with truncation toward zero
    mag = (acc < 0) ? -acc : acc;
    mag = mag >> FRAC_BITS;
    nd  = longint'(wheel[side].duty) + ((acc < 0) ? -mag : mag);
    if (nd < 0) nd = 0;
    if (nd > PWM_MAX) nd = PWM_MAX;
    wheel[side].duty = nd[DUTY_W-1:0];
    return wheel[side].duty;
  endfunction

  function automatic void predict_motor_cmd(logic [CNT_W-1:0] l, logic [CNT_W-1:0] r);
    res_t want;
    logic dist_on;
    dist_on          = ctrl_flags[FLAG_DIST];
    want.left_duty   = pid_wheel_step(0, l, dist_on);
    want.right_duty  = pid_wheel_step(1, r, dist_on);
    want.left_dir    = ctrl_flags[FLAG_LDIR];
    want.right_dir   = ctrl_flags[FLAG_RDIR];
    want.left_done   = wheel[0].done;
    want.right_done  = wheel[1].done;
    motor_cmd_q.push_back(want);
  endfunction

  // Register write; the model takes the value at once since the block is idle
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_KP:    gain_kp = val[GAIN_W-1:0];
      REG_KI:    gain_ki = val[GAIN_W-1:0];
      REG_KD:    gain_kd = val[GAIN_W-1:0];
      REG_LTGT:  wheel[0].target = val[CNT_W-1:0];
      REG_RTGT:  wheel[1].target = val[CNT_W-1:0];
      REG_LDIST: begin
        wheel[0].limit  = val[DIST_W-1:0];
        wheel[0].travel = '0;
        wheel[0].done   = 1'b0;
      end
      REG_RDIST: begin
        wheel[1].limit  = val[DIST_W-1:0];
        wheel[1].travel = '0;
        wheel[1].done   = 1'b0;
      end
      REG_FLAGS: ctrl_flags = val[FLAG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic close_writes();
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Stop sending and let every pending result come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (motor_cmd_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(logic [GAIN_W-1:0] kp, ki, kd, logic [CNT_W-1:0] lt, rt,
                               logic [DIST_W-1:0] ld, rd, logic [FLAG_W-1:0] fl);
    wait_drained();
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_LTGT, lt);
    write_reg(REG_RTGT, rt);
    write_reg(REG_LDIST, ld);
    write_reg(REG_RDIST, rd);
    write_reg(REG_FLAGS, fl);
    close_writes();
  endtask

  // Send one sample pair; called at a clock edge, returns at the accepting edge
  task automatic send_sample(logic [CNT_W-1:0] l, logic [CNT_W-1:0] r);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.left_count  <= l;
    in_ch.right_count <= r;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_motor_cmd(l, r);
  endtask

  // Random draws, biased toward the range where the duty moves
  function automatic logic [GAIN_W-1:0] draw_gain();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 800)) - 16'd400;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] draw_target();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] draw_limit();
    case ($urandom_range(0, 7))
      0: return 31'h7FFF_FFFF;
      1: return '0;
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 40000));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] draw_count(logic [CNT_W-1:0] tgt);
    int v;
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return '0;
      2: return '1;
      default: begin
        v = int'(tgt) + int'($urandom_range(0, 400)) - 200;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // Reset gains and targets, no register written yet
  task automatic test_reset_values();
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'h0001, 16'hFFFF);
  endtask

  // Mid-range duty, then gains and counts at their extremes
  task automatic test_pid_extremes();
    apply_setting(16'd256, 16'd16, 16'd128, 16'd50, 16'hFFFF, 31'd0, 31'd0, 3'b110);
    send_sample(16'd40, 16'h0000);
    send_sample(16'd60, 16'hFFFF);
    send_sample(16'd50, 16'h8000);
    send_sample(16'd0, 16'h0001);
    apply_setting(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 31'd0, 31'd0, 3'b000);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'h0000, 16'h0000);
    apply_setting(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 31'd0, 31'd0, 3'b010);
    send_sample(16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hAAAA, 16'h5555);
  endtask

  // Travel limit reached, held with distance mode off, cleared by a rewrite
  task automatic test_distance_limit();
    apply_setting(16'd256, 16'd0, 16'd0, 16'd100, 16'd100, 31'd10, 31'd0, 3'b101);
    send_sample(16'd5, 16'd0);
    send_sample(16'd5, 16'd0);
    send_sample(16'd1, 16'd0);
    send_sample(16'd0, 16'd1);
    send_sample(16'd3, 16'd3);
    wait_drained();
    write_reg(REG_FLAGS, 3'b100);
    close_writes();
    send_sample(16'd7, 16'd7);
    wait_drained();
    write_reg(REG_LDIST, 31'd1000);
    close_writes();
    send_sample(16'd7, 16'd7);
  endtask

  // Back-to-back runs at full count: integrals and left travel grow at top speed
  task automatic test_full_count();
    idle_on = 1'b0;
    apply_setting(16'd0, 16'hFFFF, 16'd0, 16'h0000, 16'hFFFF, 31'd0, 31'd0, 3'b000);
    for (int n = 0; n < 40; n++) send_sample(16'hFFFF, 16'h0000);
    wait_drained();
    write_reg(REG_LDIST, 31'h7FFF_FFFF);
    write_reg(REG_RDIST, 31'd0);
    write_reg(REG_FLAGS, 3'b001);
    close_writes();
    for (int n = 0; n < 40; n++) send_sample(16'hFFFF, 16'h0000);
  endtask

  // Random settings per phase, random samples around the targets
  task automatic test_random_mix();
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      apply_setting(draw_gain(), draw_gain(), draw_gain(), draw_target(), draw_target(),
                    draw_limit(), draw_limit(), 3'($urandom_range(0, 7)));
      for (int n = 0; n < 50; n++)
        send_sample(draw_count(wheel[0].target), draw_count(wheel[1].target));
    end
  endtask

  // ------------------------------------------------------------- checking

  task automatic check_field(string name, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : check_result
    res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (motor_cmd_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual duty %0d/%0d",
                 $time, out_ch.left_duty_out, out_ch.right_duty_out);
        err_count++;
      end else begin
        want = motor_cmd_q.pop_front();
        check_field("left_duty_out", want.left_duty, out_ch.left_duty_out);
        check_field("right_duty_out", want.right_duty, out_ch.right_duty_out);
        check_field("left_dir_out", want.left_dir, out_ch.left_dir_out);
        check_field("right_dir_out", want.right_dir, out_ch.right_dir_out);
        check_field("left_done_out", want.left_done, out_ch.left_done_out);
        check_field("right_done_out", want.right_done, out_ch.right_done_out);
      end
    end
  end

  // Result side: random stall after each item while idle_on is set
  initial begin : result_sink
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        hold = idle_on ? $urandom_range(0, 15) : 0;
        out_ch.ready <= (hold == 0);
      end else if (hold > 0) begin
        hold--;
        if (hold == 0) out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("dual_motor_pid_distance_control regression: fail");
    $finish;
  end

  // Main sequence
  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= REG_KP;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.left_count  <= '0;
    in_ch.right_count <= '0;
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_values();
    test_pid_extremes();
    test_distance_limit();
    test_full_count();
    test_random_mix();

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("dual_motor_pid_distance_control regression: pass");
    end else begin
      $display("dual_motor_pid_distance_control regression: fail");
    end
    $finish;
  end

endmodule

FILE: dual_motor_pid_distance_control.f
+incdir+design
design/dmpdc_pkg.sv
design/dmpdc_in_if.sv
design/dmpdc_out_if.sv
design/dmpdc_cfg.sv
design/dmpdc_chan.sv
design/dual_motor_pid_distance_control.sv
verif/tb.sv
